FILE: rtl/core/obt_pkg.sv
// Package for the order book top levels block: sizes, action codes,
// memory entry layouts and stream widths.
// No dependencies.
package obt_pkg;

  localparam int unsigned OrderSlots    = 1024;
  localparam int unsigned LevelSlots    = 64;
  localparam int unsigned SnapshotDepth = 10;

  localparam logic [2:0] ActReset  = 3'd0;
  localparam logic [2:0] ActAdd    = 3'd1;
  localparam logic [2:0] ActCancel = 3'd2;
  localparam logic [2:0] ActFill   = 3'd3;

  localparam logic SideBid = 1'b0;
  localparam logic SideAsk = 1'b1;

  localparam logic [30:0] QtyMax = 31'h7FFF_FFFF;

  localparam int unsigned InDataW  = 192;
  localparam int unsigned InUserW  = 5;
  localparam int unsigned OutDataW = 136;
  localparam int unsigned OutUserW = 3;

  typedef struct packed {
    logic        used;
    logic [62:0] ident;
    logic [31:0] price;
    logic [30:0] rem;
    logic [1:0]  side;
  } order_ent_t;

  typedef struct packed {
    logic [31:0] price;
    logic [30:0] qty;
  } level_ent_t;

endpackage

FILE: rtl/core/order_book_top_levels.sv
// Top level of the order book top levels block: event sequencer around the
// order table and price level memories. Depends on obt_pkg,
// obt_order_store and obt_level_store.
//
// channel | dir | tdata                              | tuser                 | tlast
// s_axis  | in  | order_key, price_ticks, quantity,  | action, book_side     | -
//         |     | stamp                              |                       |
// m_axis  | out | stamp_out, level_rank, level_price,| level_side,           | last_of_
//         |     | level_qty                          | level_present,overflow| snapshot
//
// One event at a time. Add, cancel and fill scan all ORDER_SLOTS order
// entries, then, if they change an order whose book_side[1] is clear, scan
// that side's levels and shift levels through StShRd and StShWr. A book
// reset, unless it is the first event after reset, sweeps the order table.
// The snapshot sends each result through StSnapRd and StSnapWr and waits
// while m_axis stalls. After reset a clearing pass runs with s_axis_tready low.
module order_book_top_levels #(
  parameter int unsigned ORDER_SLOTS    = obt_pkg::OrderSlots,
  parameter int unsigned LEVEL_SLOTS    = obt_pkg::LevelSlots,
  parameter int unsigned SNAPSHOT_DEPTH = obt_pkg::SnapshotDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // order_key[62:0], price_ticks[94:63], quantity[125:95], stamp[189:126]
  input  logic [obt_pkg::InDataW-1:0]   s_axis_tdata,
  // action[2:0], book_side[4:3]
  input  logic [obt_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // stamp_out[63:0], level_rank[67:64], level_price[99:68], level_qty[130:100]
  output logic [obt_pkg::OutDataW-1:0]  m_axis_tdata,
  // level_side[0], level_present[1], overflow[2]
  output logic [obt_pkg::OutUserW-1:0]  m_axis_tuser,
  output logic                          m_axis_tlast
);

  localparam int unsigned OW  = $clog2(ORDER_SLOTS);
  localparam int unsigned OCW = $clog2(ORDER_SLOTS + 1);
  localparam int unsigned LW  = $clog2(LEVEL_SLOTS);
  localparam int unsigned CW  = $clog2(LEVEL_SLOTS + 1);
  localparam int unsigned RW  = $clog2(SNAPSHOT_DEPTH + 1);

  typedef enum logic [10:0] {
    StIdle   = 11'b000_0000_0001,
    StClr    = 11'b000_0000_0010,
    StOScan  = 11'b000_0000_0100,
    StOEval  = 11'b000_0000_1000,
    StLScan  = 11'b000_0001_0000,
    StLEval  = 11'b000_0010_0000,
    StShRd   = 11'b000_0100_0000,
    StShWr   = 11'b000_1000_0000,
    StLIns   = 11'b001_0000_0000,
    StSnapRd = 11'b010_0000_0000,
    StSnapWr = 11'b100_0000_0000
  } state_e;

  function automatic logic ranks_before(logic side, logic [31:0] a, logic [31:0] b);
    ranks_before = (side == obt_pkg::SideBid) ? (a > b) : (a < b);
  endfunction

  // control state
  state_e         state_q, state_d;
  logic           first_q, first_d;
  logic           clr_snap_q, clr_snap_d;
  logic [OCW-1:0] oc_q, oc_d;
  logic [CW-1:0]  cnt_q [2];
  logic [CW-1:0]  cnt_d [2];
  logic [CW-1:0]  lc_q, lc_d;
  logic           m_valid_q, m_valid_d;

  // payload
  logic [2:0]     act_q, act_d;
  logic [1:0]     side_q, side_d;
  logic [62:0]    key_q, key_d;
  logic [31:0]    price_q, price_d;
  logic [30:0]    qty_q, qty_d;
  logic [63:0]    stamp_q, stamp_d;
  logic           ovf_q, ovf_d;
  logic           match_q, match_d;
  logic [OW-1:0]  mslot_q, mslot_d;
  logic [31:0]    mprice_q, mprice_d;
  logic [30:0]    mrem_q, mrem_d;
  logic [1:0]     mside_q, mside_d;
  logic           free_q, free_d;
  logic [OW-1:0]  fslot_q, fslot_d;
  logic           lside_q, lside_d;
  logic [31:0]    lprice_q, lprice_d;
  logic           ladd_q, ladd_d;
  logic [30:0]    lamt_q, lamt_d;
  logic           found_q, found_d;
  logic [LW-1:0]  fidx_q, fidx_d;
  logic [30:0]    fqty_q, fqty_d;
  logic           jset_q, jset_d;
  logic [CW-1:0]  jpos_q, jpos_d;
  logic [LW-1:0]  shsrc_q, shsrc_d;
  logic           shup_q, shup_d;
  logic           ss_q, ss_d;
  logic [RW-1:0]  rk_q, rk_d;
  logic [obt_pkg::OutDataW-1:0] m_data_q, m_data_d;
  logic [obt_pkg::OutUserW-1:0] m_user_q, m_user_d;
  logic           m_last_q, m_last_d;

  // memory ports
  logic                 o_we, o_re;
  logic [OW-1:0]        o_waddr, o_raddr;
  obt_pkg::order_ent_t  o_wdata, o_rdata;
  logic                 l_we, l_re;
  logic [LW:0]          l_waddr, l_raddr;
  obt_pkg::level_ent_t  l_wdata, l_rdata;

  obt_order_store #(.ORDER_SLOTS(ORDER_SLOTS)) u_orders (
    .clk_i   (clk_i),
    .we_i    (o_we),
    .waddr_i (o_waddr),
    .wdata_i (o_wdata),
    .re_i    (o_re),
    .raddr_i (o_raddr),
    .rdata_o (o_rdata)
  );

  obt_level_store #(.LEVEL_SLOTS(LEVEL_SLOTS)) u_levels (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .re_i    (l_re),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  logic [2:0]   in_act;
  logic [1:0]   in_side;
  logic [62:0]  in_key;
  logic [30:0]  in_qty;
  logic [CW-1:0] n_lvl;
  logic         snap_present;
  logic         out_free;
  logic [31:0]  sat_sum;

  assign in_act  = s_axis_tuser[2:0];
  assign in_side = s_axis_tuser[4:3];
  assign in_key  = s_axis_tdata[62:0];
  assign in_qty  = s_axis_tdata[125:95];
  assign n_lvl   = cnt_q[lside_q];
  assign snap_present = 32'(rk_q) < 32'(cnt_q[ss_q]);
  assign out_free = !m_valid_q || m_axis_tready;
  assign sat_sum  = {1'b0, fqty_q} + {1'b0, lamt_q};

  always_comb begin
    state_d = state_q;  first_d = first_q;  clr_snap_d = clr_snap_q;
    oc_d = oc_q;  cnt_d = cnt_q;  lc_d = lc_q;
    act_d = act_q;  side_d = side_q;  key_d = key_q;  price_d = price_q;
    qty_d = qty_q;  stamp_d = stamp_q;  ovf_d = ovf_q;
    match_d = match_q;  mslot_d = mslot_q;  mprice_d = mprice_q;
    mrem_d = mrem_q;  mside_d = mside_q;  free_d = free_q;  fslot_d = fslot_q;
    lside_d = lside_q;  lprice_d = lprice_q;  ladd_d = ladd_q;  lamt_d = lamt_q;
    found_d = found_q;  fidx_d = fidx_q;  fqty_d = fqty_q;
    jset_d = jset_q;  jpos_d = jpos_q;  shsrc_d = shsrc_q;  shup_d = shup_q;
    ss_d = ss_q;  rk_d = rk_q;
    m_data_d = m_data_q;  m_user_d = m_user_q;  m_last_d = m_last_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    o_we = 1'b0;  o_waddr = '0;  o_wdata = '0;  o_re = 1'b0;  o_raddr = '0;
    l_we = 1'b0;  l_waddr = '0;  l_wdata = '0;  l_re = 1'b0;  l_raddr = '0;

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          act_d   = in_act;
          side_d  = in_side;
          key_d   = in_key;
          price_d = s_axis_tdata[94:63];
          qty_d   = in_qty;
          stamp_d = s_axis_tdata[189:126];
          ovf_d   = 1'b0;
          first_d = 1'b0;
          match_d = 1'b0;
          free_d  = 1'b0;
          oc_d    = '0;
          ss_d    = 1'b0;
          rk_d    = '0;
          if (first_q && in_act == obt_pkg::ActReset) begin
            state_d = StIdle;
          end else if (in_act == obt_pkg::ActReset) begin
            cnt_d[0]   = '0;
            cnt_d[1]   = '0;
            clr_snap_d = 1'b1;
            state_d    = StClr;
          end else if ((in_act == obt_pkg::ActAdd && in_key != '0 && in_qty != '0) ||
                       in_act == obt_pkg::ActCancel ||
                       (in_act == obt_pkg::ActFill && in_qty != '0)) begin
            state_d = StOScan;
          end else begin
            state_d = StSnapRd;
          end
        end
      end

      StClr: begin
        o_we    = 1'b1;
        o_waddr = OW'(oc_q);
        o_wdata = '0;
        oc_d    = oc_q + 1'b1;
        if (oc_q == OCW'(ORDER_SLOTS - 1)) begin
          state_d = clr_snap_q ? StSnapRd : StIdle;
          ss_d    = 1'b0;
          rk_d    = '0;
        end
      end

      StOScan: begin
        if (oc_q != OCW'(ORDER_SLOTS)) begin
          o_re    = 1'b1;
          o_raddr = OW'(oc_q);
        end
        if (oc_q != '0) begin
          if (o_rdata.used && o_rdata.ident == key_q && !match_q) begin
            match_d  = 1'b1;
            mslot_d  = OW'(oc_q - 1'b1);
            mprice_d = o_rdata.price;
            mrem_d   = o_rdata.rem;
            mside_d  = o_rdata.side;
          end
          if (!o_rdata.used && !free_q) begin
            free_d  = 1'b1;
            fslot_d = OW'(oc_q - 1'b1);
          end
        end
        if (oc_q == OCW'(ORDER_SLOTS)) begin
          state_d = StOEval;
        end else begin
          oc_d = oc_q + 1'b1;
        end
      end

      StOEval: begin
        ss_d = 1'b0;
        rk_d = '0;
        state_d = StSnapRd;
        lprice_d = mprice_q;
        lside_d  = mside_q[0];
        ladd_d   = 1'b0;
        lamt_d   = qty_q;
        o_wdata.used  = 1'b1;
        o_wdata.ident = key_q;
        o_wdata.price = mprice_q;
        o_wdata.rem   = mrem_q;
        o_wdata.side  = mside_q;
        o_waddr = mslot_q;
        case (act_q)
          obt_pkg::ActAdd: begin
            if (!match_q && !free_q) begin
              ovf_d = 1'b1;
            end else begin
              o_we          = 1'b1;
              o_waddr       = match_q ? mslot_q : fslot_q;
              o_wdata.price = price_q;
              o_wdata.rem   = qty_q;
              o_wdata.side  = side_q;
              lprice_d = price_q;
              lside_d  = side_q[0];
              ladd_d   = 1'b1;
              if (!side_q[1]) begin
                state_d = StLScan;
              end
            end
          end
          obt_pkg::ActCancel: begin
            if (match_q) begin
              o_we         = 1'b1;
              o_wdata.used = 1'b0;
              lamt_d       = mrem_q;
              if (!mside_q[1]) begin
                state_d = StLScan;
              end
            end
          end
          obt_pkg::ActFill: begin
            if (match_q) begin
              o_we = 1'b1;
              if (mrem_q <= qty_q) begin
                o_wdata.used = 1'b0;
              end else begin
                o_wdata.rem = mrem_q - qty_q;
              end
              if (!mside_q[1]) begin
                state_d = StLScan;
              end
            end
          end
          default: begin
            state_d = StSnapRd;
          end
        endcase
        lc_d    = '0;
        found_d = 1'b0;
        jset_d  = 1'b0;
        jpos_d  = cnt_q[lside_d];
      end

      StLScan: begin
        if (lc_q != n_lvl) begin
          l_re    = 1'b1;
          l_raddr = {lside_q, LW'(lc_q)};
        end
        if (lc_q != '0) begin
          if (!found_q && l_rdata.price == lprice_q) begin
            found_d = 1'b1;
            fidx_d  = LW'(lc_q - 1'b1);
            fqty_d  = l_rdata.qty;
          end
          if (!jset_q && ranks_before(lside_q, lprice_q, l_rdata.price)) begin
            jset_d = 1'b1;
            jpos_d = lc_q - 1'b1;
          end
        end
        if (lc_q == n_lvl) begin
          state_d = StLEval;
        end else begin
          lc_d = lc_q + 1'b1;
        end
      end

      StLEval: begin
        state_d = StSnapRd;
        l_waddr = {lside_q, fidx_q};
        l_wdata.price = lprice_q;
        if (found_q) begin
          if (ladd_q) begin
            l_we = 1'b1;
            l_wdata.qty = sat_sum[31] ? obt_pkg::QtyMax : sat_sum[30:0];
          end else if (fqty_q <= lamt_q) begin
            if (CW'(fidx_q) + 1'b1 < n_lvl) begin
              shsrc_d = fidx_q + 1'b1;
              shup_d  = 1'b0;
              state_d = StShRd;
            end else begin
              cnt_d[lside_q] = n_lvl - 1'b1;
            end
          end else begin
            l_we = 1'b1;
            l_wdata.qty = fqty_q - lamt_q;
          end
        end else if (ladd_q) begin
          if (n_lvl >= CW'(LEVEL_SLOTS)) begin
            ovf_d = 1'b1;
          end else if (jpos_q < n_lvl) begin
            shsrc_d = LW'(n_lvl - 1'b1);
            shup_d  = 1'b1;
            state_d = StShRd;
          end else begin
            state_d = StLIns;
          end
        end
      end

      StShRd: begin
        l_re    = 1'b1;
        l_raddr = {lside_q, shsrc_q};
        state_d = StShWr;
      end

      StShWr: begin
        l_we    = 1'b1;
        l_wdata = l_rdata;
        state_d = StShRd;
        if (shup_q) begin
          l_waddr = {lside_q, shsrc_q + 1'b1};
          if (CW'(shsrc_q) == jpos_q) begin
            state_d = StLIns;
          end else begin
            shsrc_d = shsrc_q - 1'b1;
          end
        end else begin
          l_waddr = {lside_q, shsrc_q - 1'b1};
          if (CW'(shsrc_q) == n_lvl - 1'b1) begin
            cnt_d[lside_q] = n_lvl - 1'b1;
            state_d = StSnapRd;
          end else begin
            shsrc_d = shsrc_q + 1'b1;
          end
        end
      end

      StLIns: begin
        l_we          = 1'b1;
        l_waddr       = {lside_q, LW'(jpos_q)};
        l_wdata.price = lprice_q;
        l_wdata.qty   = lamt_q;
        cnt_d[lside_q] = n_lvl + 1'b1;
        state_d = StSnapRd;
      end

      StSnapRd: begin
        if (snap_present) begin
          l_re    = 1'b1;
          l_raddr = {ss_q, LW'(rk_q)};
        end
        state_d = StSnapWr;
      end

      StSnapWr: begin
        if (out_free) begin
          m_valid_d         = 1'b1;
          m_data_d          = '0;
          m_data_d[63:0]    = stamp_q;
          m_data_d[67:64]   = 4'(rk_q);
          m_data_d[99:68]   = snap_present ? l_rdata.price : 32'd0;
          m_data_d[130:100] = snap_present ? l_rdata.qty : 31'd0;
          m_user_d          = {ovf_q, snap_present, ss_q};
          m_last_d          = ss_q && (rk_q == RW'(SNAPSHOT_DEPTH - 1));
          state_d           = StSnapRd;
          if (rk_q == RW'(SNAPSHOT_DEPTH - 1)) begin
            rk_d = '0;
            if (ss_q) begin
              state_d = StIdle;
            end else begin
              ss_d = 1'b1;
            end
          end else begin
            rk_d = rk_q + 1'b1;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClr;
      first_q    <= 1'b1;
      clr_snap_q <= 1'b0;
      oc_q       <= '0;
      cnt_q[0]   <= '0;
      cnt_q[1]   <= '0;
      lc_q       <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      first_q    <= first_d;
      clr_snap_q <= clr_snap_d;
      oc_q       <= oc_d;
      cnt_q      <= cnt_d;
      lc_q       <= lc_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;  side_q <= side_d;  key_q <= key_d;  price_q <= price_d;
    qty_q <= qty_d;  stamp_q <= stamp_d;  ovf_q <= ovf_d;
    match_q <= match_d;  mslot_q <= mslot_d;  mprice_q <= mprice_d;
    mrem_q <= mrem_d;  mside_q <= mside_d;  free_q <= free_d;  fslot_q <= fslot_d;
    lside_q <= lside_d;  lprice_q <= lprice_d;  ladd_q <= ladd_d;  lamt_q <= lamt_d;
    found_q <= found_d;  fidx_q <= fidx_d;  fqty_q <= fqty_d;
    jset_q <= jset_d;  jpos_q <= jpos_d;  shsrc_q <= shsrc_d;  shup_q <= shup_d;
    ss_q <= ss_d;  rk_q <= rk_d;
    m_data_q <= m_data_d;  m_user_q <= m_user_d;  m_last_q <= m_last_d;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule

FILE: rtl/core/obt_order_store.sv
// Order table memory: one entry per order slot, one write and one
// registered read port. Depends on obt_pkg.
module obt_order_store #(
  parameter int unsigned ORDER_SLOTS = obt_pkg::OrderSlots
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ORDER_SLOTS)-1:0] waddr_i,
  input  obt_pkg::order_ent_t        wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(ORDER_SLOTS)-1:0] raddr_i,
  output obt_pkg::order_ent_t        rdata_o
);

  obt_pkg::order_ent_t mem_q [ORDER_SLOTS];
  obt_pkg::order_ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/obt_level_store.sv
// Price level memory for both sides, addressed by {side, index}, one write
// and one registered read port. Depends on obt_pkg.
module obt_level_store #(
  parameter int unsigned LEVEL_SLOTS = obt_pkg::LevelSlots
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(LEVEL_SLOTS):0]  waddr_i,
  input  obt_pkg::level_ent_t           wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(LEVEL_SLOTS):0]  raddr_i,
  output obt_pkg::level_ent_t           rdata_o
);

  localparam int unsigned Depth = 2 << $clog2(LEVEL_SLOTS);

  obt_pkg::level_ent_t mem_q [Depth];
  obt_pkg::level_ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/obt_checker.sv
// Port-level checks for order_book_top_levels, bound to the top level.
// Depends on obt_pkg.
module obt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [obt_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [obt_pkg::OutUserW-1:0]  m_axis_tuser,
  input logic                          m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_last_is_ask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("last transfer not on ask side");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[130:68] == '0)
    else $error("padding level carries price or quantity");

endmodule

bind order_book_top_levels obt_checker u_obt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
